>>> hdl/lru_page_replacement_top_assert.svh
// Assertion macros used by the RTL of the page replacement block (lru_frame_state).
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define LRU_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lru assertion failed");
// Next-cycle implication, disabled while reset is high.
`define LRU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lru assertion failed");
`else
`define LRU_ASSERT_SAME(label, clk_s, rst_s, ante, cons)
`define LRU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

>>> hdl/lru_pkg.sv
`default_nettype none
package lru_pkg;

  localparam int MAX_FRAMES        = 8;
  localparam int PAGE_BITS         = 8;
  localparam int FRAME_BITS        = 3;
  localparam int COUNT_BITS        = 16;
  localparam int CFG_BITS          = 4;
  localparam int FRAME_COUNT_RESET = 4;

  typedef logic [MAX_FRAMES-1:0][PAGE_BITS-1:0]  page_arr_t;
  typedef logic [MAX_FRAMES-1:0][FRAME_BITS-1:0] rank_arr_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 last;
  } lru_in_t;

  typedef struct packed {
    logic                  fault;
    logic [FRAME_BITS-1:0] frame;
    logic [COUNT_BITS-1:0] fault_count;
  } lru_out_t;

  // Outcome of the lookup for one reference.
  typedef struct packed {
    logic                  hit;
    logic                  empty;
    logic [FRAME_BITS-1:0] frame;
  } lru_sel_t;

  // Update request from the top level to the frame state.
  typedef struct packed {
    logic                  en;
    logic                  hit;
    logic                  empty;
    logic                  last;
    logic [FRAME_BITS-1:0] frame;
    logic [PAGE_BITS-1:0]  page;
  } lru_upd_t;

endpackage
`default_nettype wire

>>> hdl/lru_select.sv
`default_nettype none
module lru_select (
  input  wire logic [lru_pkg::PAGE_BITS-1:0]  page,
  input  wire logic [lru_pkg::MAX_FRAMES-1:0] in_use,
  input  wire lru_pkg::page_arr_t             frame_page,
  input  wire logic [lru_pkg::MAX_FRAMES-1:0] frame_valid,
  input  wire lru_pkg::rank_arr_t             recency_rank,
  output lru_pkg::lru_sel_t                   sel
);
  import lru_pkg::*;

  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] free;
  logic [MAX_FRAMES-1:0] is_oldest;

  function automatic logic [FRAME_BITS-1:0] lowest_index(logic [MAX_FRAMES-1:0] m);
    logic [FRAME_BITS-1:0] idx;
    idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (m[i]) idx = FRAME_BITS'(i);
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = in_use[i] && frame_valid[i] && (frame_page[i] == page);
      free[i]  = in_use[i] && !frame_valid[i];
      // A frame in use whose rank is not below any other frame in use.
      is_oldest[i] = in_use[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (in_use[j] && (recency_rank[j] > recency_rank[i])) is_oldest[i] = 1'b0;
      end
    end
  end

  always_comb begin
    sel.hit   = |match;
    sel.empty = |free;
    if (sel.hit) begin
      sel.frame = lowest_index(match);
    end else if (sel.empty) begin
      sel.frame = lowest_index(free);
    end else begin
      sel.frame = lowest_index(is_oldest);
    end
  end

endmodule
`default_nettype wire

>>> hdl/lru_frame_state.sv
`default_nettype none
`include "lru_page_replacement_top_assert.svh"
module lru_frame_state (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lru_pkg::lru_upd_t              upd,
  output lru_pkg::page_arr_t                  frame_page,
  output logic [lru_pkg::MAX_FRAMES-1:0]      frame_valid,
  output lru_pkg::rank_arr_t                  recency_rank,
  output logic [lru_pkg::COUNT_BITS-1:0]      faults_next
);
  import lru_pkg::*;

  logic [COUNT_BITS-1:0] faults_so_far;
  logic [MAX_FRAMES-1:0] frame_valid_next;
  rank_arr_t             recency_rank_next;
  page_arr_t             frame_page_next;
  logic [FRAME_BITS-1:0] limit;
  logic                  age_all;

  assign faults_next = (!upd.hit && (faults_so_far != {COUNT_BITS{1'b1}})) ?
                       faults_so_far + COUNT_BITS'(1) : faults_so_far;

  // Filling an empty frame ages every valid frame; otherwise only frames
  // more recent than the touched one age.
  assign limit   = recency_rank[upd.frame];
  assign age_all = !upd.hit && upd.empty;

  always_comb begin
    frame_valid_next  = frame_valid;
    recency_rank_next = recency_rank;
    frame_page_next   = frame_page;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if ((FRAME_BITS'(i) != upd.frame) && frame_valid[i] &&
          (age_all || (recency_rank[i] < limit))) begin
        recency_rank_next[i] = recency_rank[i] + FRAME_BITS'(1);
      end
    end
    recency_rank_next[upd.frame] = '0;
    if (!upd.hit) begin
      frame_valid_next[upd.frame] = 1'b1;
      frame_page_next[upd.frame]  = upd.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      recency_rank  <= '0;
      faults_so_far <= '0;
    end else if (upd.en) begin
      if (upd.last) begin
        frame_valid   <= '0;
        recency_rank  <= '0;
        faults_so_far <= '0;
      end else begin
        frame_valid   <= frame_valid_next;
        recency_rank  <= recency_rank_next;
        faults_so_far <= faults_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) frame_page <= frame_page_next;
  end

  `LRU_ASSERT_NEXT(a_touched_valid, clk, rst, upd.en && !upd.last, frame_valid[$past(upd.frame)])
  `LRU_ASSERT_NEXT(a_touched_newest, clk, rst, upd.en && !upd.last, recency_rank[$past(upd.frame)] == '0)
  `LRU_ASSERT_NEXT(a_last_clears, clk, rst, upd.en && upd.last, (frame_valid == '0) && (faults_so_far == '0))
  `LRU_ASSERT_NEXT(a_count_holds, clk, rst, !upd.en, $stable(faults_so_far))

endmodule
`default_nettype wire

>>> hdl/lru_page_replacement_top.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_data  (page, last)
// out      out_valid / out_ready   out_data (fault, frame, fault_count)
// cfg      cfg_we                  cfg_data (frame_count)
//
// One reference per cycle is sustained while out_ready is high; a result passes
// through the input register and then the result register, with the lookup
// and update done between them.
// Synchronous reset empties all frames, clears the fault count and sets
// frame_count to 4; no clearing pass is needed.
// A stalled result holds the pipeline; in_ready drops only when both registers
// are full and the result is not being taken.
`default_nettype none
module lru_page_replacement_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lru_pkg::lru_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lru_pkg::lru_out_t                 out_data,
  input  wire logic                         cfg_we,
  input  wire logic [lru_pkg::CFG_BITS-1:0] cfg_data
);
  import lru_pkg::*;

  logic                  in_valid_q;
  lru_in_t               in_q;
  logic [CFG_BITS-1:0]   frame_count;
  logic [CFG_BITS-1:0]   used;
  logic [MAX_FRAMES-1:0] in_use;
  logic                  fire;

  page_arr_t             frame_page;
  logic [MAX_FRAMES-1:0] frame_valid;
  rank_arr_t             recency_rank;
  logic [COUNT_BITS-1:0] faults_next;
  lru_sel_t              sel;
  lru_upd_t              upd;

  assign fire     = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || fire;

  always_comb begin
    if (frame_count == '0) begin
      used = CFG_BITS'(1);
    end else if (frame_count > CFG_BITS'(MAX_FRAMES)) begin
      used = CFG_BITS'(MAX_FRAMES);
    end else begin
      used = frame_count;
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      in_use[i] = CFG_BITS'(i) < used;
    end
  end

  lru_select u_select (
    .page         (in_q.page),
    .in_use       (in_use),
    .frame_page   (frame_page),
    .frame_valid  (frame_valid),
    .recency_rank (recency_rank),
    .sel          (sel)
  );

  always_comb begin
    upd.en    = fire;
    upd.hit   = sel.hit;
    upd.empty = sel.empty;
    upd.last  = in_q.last;
    upd.frame = sel.frame;
    upd.page  = in_q.page;
  end

  lru_frame_state u_state (
    .clk          (clk),
    .rst          (rst),
    .upd          (upd),
    .frame_page   (frame_page),
    .frame_valid  (frame_valid),
    .recency_rank (recency_rank),
    .faults_next  (faults_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      out_valid   <= 1'b0;
      frame_count <= CFG_BITS'(FRAME_COUNT_RESET);
    end else begin
      if (cfg_we) frame_count <= cfg_data;
      if (in_ready) in_valid_q <= in_valid;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_data;
    if (fire) begin
      out_data.fault       <= !sel.hit;
      out_data.frame       <= sel.frame;
      out_data.fault_count <= faults_next;
    end
  end

endmodule
`default_nettype wire
